FILE: hdl/bst_pkg.sv
`timescale 1ns / 1ps
// Types and codes for the array-based binary search tree unit.
// No dependencies.
package bst_pkg;
	localparam int CFG_W   = 7;
	localparam int OP_W    = 3;
	localparam int STAT_W  = 3;
	localparam int VALUE_W = 32;

	typedef logic [OP_W-1:0]    op_t;
	typedef logic [STAT_W-1:0]  status_t;
	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [CFG_W-1:0]   cfg_t;

	localparam op_t OP_INSERT   = 3'd0;
	localparam op_t OP_INORDER  = 3'd1;
	localparam op_t OP_PREORDER = 3'd2;
	localparam op_t OP_POSTORD  = 3'd3;
	localparam op_t OP_LEVEL    = 3'd4;
	localparam op_t OP_COMPLETE = 3'd5;

	localparam status_t ST_INSERTED = 3'd0;
	localparam status_t ST_DUP      = 3'd1;
	localparam status_t ST_FULL     = 3'd2;
	localparam status_t ST_ELEM     = 3'd3;
	localparam status_t ST_EMPTY    = 3'd4;
	localparam status_t ST_ANSWER   = 3'd5;
endpackage

FILE: hdl/array_bst_insert_traverse_unit.sv
`timescale 1ns / 1ps
// Operation: insert walks down one tree level per compare; a traversal follows an Euler
// tour (three tour steps per stored node, plus an emit step and a repeated step for each
// emitted node); level order scans each slot in use and emits the reached ones; the
// completeness query scans each slot in use.
// Commands: one at a time; the single read port on the node store and the tour sequencer
// set the pace, and result stalls can hold it.
// Reset: asynchronous active low; empties the tree (all slot valid bits cleared) and sets
// the slot count to 64. Node store contents are not cleared.
module array_bst_insert_traverse_unit #(
	parameter int MAX_SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  bst_pkg::op_t      op,
	input  bst_pkg::value_t   key_value,
	output logic              result_valid,
	input  logic              result_stall,
	output bst_pkg::status_t  status,
	output bst_pkg::value_t   node_value,
	output logic              is_complete,
	output logic              last,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  bst_pkg::cfg_t     cfg_data
);
	import bst_pkg::*;

	localparam int IW = $clog2(MAX_SLOTS);
	localparam int PW = IW + 1;
	localparam cfg_t MAX_CFG = CFG_W'(MAX_SLOTS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_INS   = 4'd1;
	localparam logic [3:0] S_INCMP = 4'd2;
	localparam logic [3:0] S_ONE   = 4'd3;
	localparam logic [3:0] S_DOWN  = 4'd4;
	localparam logic [3:0] S_LEFT  = 4'd5;
	localparam logic [3:0] S_RIGHT = 4'd6;
	localparam logic [3:0] S_LVL   = 4'd7;
	localparam logic [3:0] S_EMIT  = 4'd8;
	localparam logic [3:0] S_FLUSH = 4'd9;
	localparam logic [3:0] S_CMP   = 4'd10;

	logic [3:0]           state_q, ret_q;
	op_t                  op_q;
	value_t               key_q;
	logic [PW-1:0]        pos_q;
	logic                 done_q;
	logic                 gap_q;
	status_t              res_status_q;
	logic                 res_ok_q;
	value_t               pend_q;
	logic                 pend_valid_q;
	cfg_t                 slots_q;
	logic [MAX_SLOTS-1:0] slot_valid_q;
	logic [MAX_SLOTS-1:0] reach_q;
	value_t               node_mem [MAX_SLOTS];
	value_t               rd_data_q;

	logic                 out_valid_q;
	status_t              out_status_q;
	value_t               out_value_q;
	logic                 out_complete_q;
	logic                 out_last_q;

	logic [PW-1:0]        lim;
	logic [PW-1:0]        left_pos, right_pos;
	logic                 here_ok, left_ok, right_ok;
	logic                 out_free;
	logic                 out_load;
	logic                 reached;
	logic                 wr_en;

	assign item_stall   = (state_q != S_IDLE);
	assign cfg_ready    = (state_q == S_IDLE);
	assign result_valid = out_valid_q;
	assign status       = out_status_q;
	assign node_value   = out_value_q;
	assign is_complete  = out_complete_q;
	assign last         = out_last_q;

	// Output word register frees when empty or being taken this cycle
	assign out_free = !out_valid_q || !result_stall;

	// A new word enters the output register this cycle
	assign out_load = out_free && ((state_q == S_ONE) || (state_q == S_FLUSH)
		|| ((state_q == S_EMIT) && pend_valid_q));

	// Effective slot count, clamped to 2..MAX_SLOTS
	always_comb begin
		if (slots_q < CFG_W'(2)) begin
			lim = PW'(2);
		end else if (slots_q > MAX_CFG) begin
			lim = PW'(MAX_SLOTS);
		end else begin
			lim = slots_q[PW-1:0];
		end
	end

	assign left_pos  = {pos_q[PW-2:0], 1'b0};
	assign right_pos = {pos_q[PW-2:0], 1'b1};
	assign here_ok   = (pos_q < lim) && slot_valid_q[pos_q[IW-1:0]];
	assign left_ok   = (left_pos < lim) && slot_valid_q[left_pos[IW-1:0]];
	assign right_ok  = (right_pos < lim) && slot_valid_q[right_pos[IW-1:0]];
	assign reached   = slot_valid_q[pos_q[IW-1:0]]
		&& ((pos_q == PW'(1)) || reach_q[pos_q[IW:1]]);
	assign wr_en     = (state_q == S_INS) && !here_ok && (pos_q < lim);

	// Node store: one write and one registered read port, both addressed by the walk position
	always_ff @(posedge clk) begin
		if (wr_en) begin
			node_mem[pos_q[IW-1:0]] <= key_q;
		end
		rd_data_q <= node_mem[pos_q[IW-1:0]];
	end

	// Payload registers need no reset
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item_valid) begin
			key_q <= key_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			ret_q          <= S_IDLE;
			op_q           <= OP_INSERT;
			pos_q          <= '0;
			done_q         <= 1'b0;
			gap_q          <= 1'b0;
			res_status_q   <= ST_INSERTED;
			res_ok_q       <= 1'b0;
			pend_q         <= '0;
			pend_valid_q   <= 1'b0;
			slots_q        <= CFG_W'(64);
			slot_valid_q   <= '0;
			reach_q        <= '0;
			out_valid_q    <= 1'b0;
			out_status_q   <= ST_INSERTED;
			out_value_q    <= '0;
			out_complete_q <= 1'b0;
			out_last_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				slots_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						op_q   <= op;
						pos_q  <= PW'(1);
						done_q <= 1'b0;
						gap_q  <= 1'b0;
						case (op) inside
							OP_INSERT: state_q <= S_INS;
							OP_INORDER, OP_PREORDER, OP_POSTORD, OP_LEVEL: begin
								if (!slot_valid_q[1]) begin
									res_status_q <= ST_EMPTY;
									res_ok_q     <= 1'b0;
									state_q      <= S_ONE;
								end else begin
									state_q <= (op == OP_LEVEL) ? S_LVL : S_DOWN;
								end
							end
							OP_COMPLETE: begin
								res_status_q <= ST_ANSWER;
								res_ok_q     <= slot_valid_q[1];
								state_q      <= slot_valid_q[1] ? S_CMP : S_ONE;
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_INS: begin
					if (here_ok) begin
						state_q <= S_INCMP;
					end else begin
						if (pos_q < lim) begin
							slot_valid_q[pos_q[IW-1:0]] <= 1'b1;
							res_status_q <= ST_INSERTED;
						end else begin
							res_status_q <= ST_FULL;
						end
						res_ok_q <= 1'b0;
						state_q  <= S_ONE;
					end
				end
				S_INCMP: begin
					if (rd_data_q == key_q) begin
						res_status_q <= ST_DUP;
						res_ok_q     <= 1'b0;
						state_q      <= S_ONE;
					end else begin
						// descend left when the key orders below the node
						pos_q   <= ($signed(key_q) < $signed(rd_data_q)) ? left_pos : right_pos;
						state_q <= S_INS;
					end
				end
				S_ONE: begin
					if (out_free) begin
						out_status_q   <= res_status_q;
						out_value_q    <= '0;
						out_complete_q <= res_ok_q;
						out_last_q     <= 1'b1;
						state_q        <= S_IDLE;
					end
				end
				// Euler tour: arriving from above
				S_DOWN: begin
					if (op_q == OP_PREORDER && !done_q) begin
						ret_q   <= S_DOWN;
						state_q <= S_EMIT;
					end else begin
						done_q <= 1'b0;
						if (left_ok) begin
							pos_q <= left_pos;
						end else begin
							state_q <= S_LEFT;
						end
					end
				end
				// back from the left subtree
				S_LEFT: begin
					if (op_q == OP_INORDER && !done_q) begin
						ret_q   <= S_LEFT;
						state_q <= S_EMIT;
					end else begin
						done_q <= 1'b0;
						if (right_ok) begin
							pos_q   <= right_pos;
							state_q <= S_DOWN;
						end else begin
							state_q <= S_RIGHT;
						end
					end
				end
				// back from the right subtree: climb to the parent
				S_RIGHT: begin
					if (op_q == OP_POSTORD && !done_q) begin
						ret_q   <= S_RIGHT;
						state_q <= S_EMIT;
					end else begin
						done_q <= 1'b0;
						if (pos_q == PW'(1)) begin
							state_q <= S_FLUSH;
						end else begin
							pos_q   <= pos_q >> 1;
							state_q <= pos_q[0] ? S_RIGHT : S_LEFT;
						end
					end
				end
				// Level order: slots in index order, kept when the parent was reached
				S_LVL: begin
					if (pos_q >= lim) begin
						state_q <= S_FLUSH;
					end else if (reached && !done_q) begin
						reach_q[pos_q[IW-1:0]] <= 1'b1;
						ret_q   <= S_LVL;
						state_q <= S_EMIT;
					end else begin
						reach_q[pos_q[IW-1:0]] <= reached;
						done_q <= 1'b0;
						pos_q  <= pos_q + PW'(1);
					end
				end
				// Hold one element back so the final one can carry the last mark
				S_EMIT: begin
					if (!pend_valid_q) begin
						pend_q       <= rd_data_q;
						pend_valid_q <= 1'b1;
						done_q       <= 1'b1;
						state_q      <= ret_q;
					end else if (out_free) begin
						out_status_q   <= ST_ELEM;
						out_value_q    <= pend_q;
						out_complete_q <= 1'b0;
						out_last_q     <= 1'b0;
						pend_q         <= rd_data_q;
						done_q         <= 1'b1;
						state_q        <= ret_q;
					end
				end
				S_FLUSH: begin
					if (out_free) begin
						out_status_q   <= ST_ELEM;
						out_value_q    <= pend_q;
						out_complete_q <= 1'b0;
						out_last_q     <= 1'b1;
						pend_valid_q   <= 1'b0;
						state_q        <= S_IDLE;
					end
				end
				// Completeness: any occupied slot after a hole spoils the prefix
				S_CMP: begin
					if (pos_q >= lim) begin
						state_q <= S_ONE;
					end else begin
						if (!slot_valid_q[pos_q[IW-1:0]]) begin
							gap_q <= 1'b1;
						end else if (gap_q) begin
							res_ok_q <= 1'b0;
						end
						pos_q <= pos_q + PW'(1);
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_flush_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FLUSH |-> pend_valid_q)
		else $error("flush without a held element");
	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != ST_ELEM |-> last && node_value == '0)
		else $error("non-element result not final or carries a value");
	a_slot0_unused: assert property (@(posedge clk) disable iff (!arst_n)
		!slot_valid_q[0])
		else $error("slot zero marked occupied");
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !pend_valid_q)
		else $error("element left behind at end of traversal");
`endif

endmodule
